@@ rtl/boundary_point_spacing_sampler_assert.svh @@
// ---------------------------------------------------------------------------
// boundary point spacing sampler assertion macros
// shared property forms used by the port checker
// ---------------------------------------------------------------------------
`ifndef BOUNDARY_POINT_SPACING_SAMPLER_ASSERT_SVH
`define BOUNDARY_POINT_SPACING_SAMPLER_ASSERT_SVH

// consequent must hold in the cycle after the antecedent
`define BPSS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define BPSS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

@@ rtl/bpss_pkg.sv @@
// ---------------------------------------------------------------------------
// bpss_pkg
// field widths, register indexes, reset values and control structs
// ---------------------------------------------------------------------------
package bpss_pkg;

   // fixed field widths of the words
   localparam int FIELD_W    = 12;
   localparam int COLOR_W    = 24;
   localparam int SPACING_W  = 24;
   localparam int ROW_W      = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   // register indexes
   localparam csr_idx_type CSR_TARGET_COLOR = 2'd0;
   localparam csr_idx_type CSR_SPACING_SQ   = 2'd1;
   localparam csr_idx_type CSR_ROW_WINDOW   = 2'd2;

   // register reset values
   localparam logic [COLOR_W-1:0]   TARGET_COLOR_RST = 24'd0;
   localparam logic [SPACING_W-1:0] SPACING_SQ_RST   = 24'd64;
   localparam logic [ROW_W-1:0]     ROW_WINDOW_RST   = 12'd8;

   // sequencer to distance unit
   typedef struct packed {
      logic load;
      logic sq_x;
      logic sq_y;
   } dist_ctl_type;

   // distance unit to sequencer
   typedef struct packed {
      logic too_close;
      logic evict;
   } dist_sts_type;

endpackage

@@ rtl/bpss_req_if.sv @@
// ---------------------------------------------------------------------------
// bpss_req_if
// pixel word channel: coordinates, center color and four neighbor colors
// ---------------------------------------------------------------------------
interface bpss_req_if import bpss_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               frame_start;
   logic [FIELD_W-1:0] pix_x;
   logic [FIELD_W-1:0] pix_y;
   logic [COLOR_W-1:0] center_color;
   logic [COLOR_W-1:0] up_color;
   logic [COLOR_W-1:0] right_color;
   logic [COLOR_W-1:0] down_color;
   logic [COLOR_W-1:0] left_color;

   modport source (
      output valid, frame_start, pix_x, pix_y,
      output center_color, up_color, right_color, down_color, left_color,
      input  ready
   );

   modport sink (
      input  valid, frame_start, pix_x, pix_y,
      input  center_color, up_color, right_color, down_color, left_color,
      output ready
   );
endinterface

@@ rtl/bpss_rsp_if.sv @@
// ---------------------------------------------------------------------------
// bpss_rsp_if
// contour point channel: point coordinates and store full flag
// ---------------------------------------------------------------------------
interface bpss_rsp_if import bpss_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] point_x;
   logic [FIELD_W-1:0] point_y;
   logic               store_full;

   modport source (
      output valid, point_x, point_y, store_full,
      input  ready
   );

   modport sink (
      input  valid, point_x, point_y, store_full,
      output ready
   );
endinterface

@@ rtl/boundary_point_spacing_sampler.sv @@
// ---------------------------------------------------------------------------
// boundary_point_spacing_sampler
// A non-boundary pixel is taken while idle and gives no word. A boundary
// pixel scans the point store, each point through read, difference, square
// x, square y and decide, then appends unless the store is full and emits;
// a rejection ends the scan and moves the remaining points down. The shared
// squarer and the single store read port set the pace. Reset clears the
// store count, the sequencer and the output and loads register defaults.
// ---------------------------------------------------------------------------
module boundary_point_spacing_sampler import bpss_pkg::*; #(
   parameter int MAX_POINTS = 64,
   parameter int COORD_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   bpss_req_if.sink              req_if,
   bpss_rsp_if.source            rsp_if,
   input  logic                  csr_we,
   input  csr_idx_type           csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int PTR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W = $clog2(MAX_POINTS + 1);

   typedef enum logic [9:0] {
      ST_IDLE = 10'b0000000001,
      ST_RD   = 10'b0000000010,
      ST_DIFF = 10'b0000000100,
      ST_SQX  = 10'b0000001000,
      ST_SQY  = 10'b0000010000,
      ST_DEC  = 10'b0000100000,
      ST_CPRD = 10'b0001000000,
      ST_CPWR = 10'b0010000000,
      ST_FIN  = 10'b0100000000,
      ST_EMIT = 10'b1000000000
   } state_type;

   state_type             state_in, state_ff;
   logic [COLOR_W-1:0]    target_in, target_ff;
   logic [SPACING_W-1:0]  spacing_in, spacing_ff;
   logic [ROW_W-1:0]      window_in, window_ff;
   logic [CNT_W-1:0]      count_in, count_ff;
   logic [CNT_W-1:0]      rd_ptr_in, rd_ptr_ff;
   logic [CNT_W-1:0]      wr_ptr_in, wr_ptr_ff;
   logic [COORD_BITS-1:0] cur_x_in, cur_x_ff;
   logic [COORD_BITS-1:0] cur_y_in, cur_y_ff;
   logic                  full_in, full_ff;
   logic                  rsp_valid_in, rsp_valid_ff;
   logic [FIELD_W-1:0]    rsp_x_ff, rsp_y_ff;
   logic                  rsp_full_ff;

   logic                  accept;
   logic                  is_boundary;
   logic                  rsp_load;
   logic [CNT_W-1:0]      rd_next, wr_next;
   logic                  walk_done;
   logic                  st_rd_en;
   logic                  st_wr_en;
   logic [COORD_BITS-1:0] st_rd_x, st_rd_y;
   logic [COORD_BITS-1:0] st_wr_x, st_wr_y;
   dist_ctl_type          dist_ctl;
   dist_sts_type          dist_sts;

   // point store
   bpss_store #(
      .MAX_POINTS (MAX_POINTS),
      .COORD_BITS (COORD_BITS),
      .PTR_W      (PTR_W)
   ) u_store (
      .clock   (clock),
      .rd_en   (st_rd_en),
      .rd_addr (rd_ptr_ff[PTR_W-1:0]),
      .rd_x    (st_rd_x),
      .rd_y    (st_rd_y),
      .wr_en   (st_wr_en),
      .wr_addr (wr_ptr_ff[PTR_W-1:0]),
      .wr_x    (st_wr_x),
      .wr_y    (st_wr_y)
   );

   // distance unit
   bpss_dist #(
      .COORD_BITS (COORD_BITS)
   ) u_dist (
      .clock      (clock),
      .ctl        (dist_ctl),
      .cur_x      (cur_x_ff),
      .cur_y      (cur_y_ff),
      .kept_x     (st_rd_x),
      .kept_y     (st_rd_y),
      .spacing_sq (spacing_ff),
      .row_window (window_ff),
      .sts        (dist_sts)
   );

   // boundary test and handshake
   always_comb begin
      is_boundary = (req_if.center_color == target_ff) &&
                    !((req_if.up_color    == target_ff) &&
                      (req_if.right_color == target_ff) &&
                      (req_if.down_color  == target_ff) &&
                      (req_if.left_color  == target_ff));
      req_if.ready = (state_ff == ST_IDLE);
      accept       = req_if.valid && req_if.ready;
      rd_next      = rd_ptr_ff + CNT_W'(1);
      wr_next      = wr_ptr_ff + CNT_W'(1);
      walk_done    = (rd_next == count_ff);
   end

   // configuration registers
   always_comb begin
      target_in  = target_ff;
      spacing_in = spacing_ff;
      window_in  = window_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_TARGET_COLOR: target_in  = csr_wdata[COLOR_W-1:0];
            CSR_SPACING_SQ:   spacing_in = csr_wdata[SPACING_W-1:0];
            CSR_ROW_WINDOW:   window_in  = csr_wdata[ROW_W-1:0];
            default:          target_in  = target_ff;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      full_in       = full_ff;
      st_rd_en      = 1'b0;
      st_wr_en      = 1'b0;
      st_wr_x       = st_rd_x;
      st_wr_y       = st_rd_y;
      dist_ctl      = '0;
      rsp_load      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_if.frame_start) begin
                  count_in = '0;
               end
               if (is_boundary) begin
                  cur_x_in  = COORD_BITS'(req_if.pix_x);
                  cur_y_in  = COORD_BITS'(req_if.pix_y);
                  rd_ptr_in = '0;
                  wr_ptr_in = '0;
                  if (req_if.frame_start || (count_ff == '0)) begin
                     state_in = ST_FIN;
                  end else begin
                     state_in = ST_RD;
                  end
               end
            end
         end
         ST_RD: begin
            st_rd_en = 1'b1;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            dist_ctl.load = 1'b1;
            state_in      = ST_SQX;
         end
         ST_SQX: begin
            dist_ctl.sq_x = 1'b1;
            state_in      = ST_SQY;
         end
         ST_SQY: begin
            dist_ctl.sq_y = 1'b1;
            state_in      = ST_DEC;
         end
         ST_DEC: begin
            rd_ptr_in = rd_next;
            if (dist_sts.too_close) begin
               // rejected: keep this point, close up the rest of the list
               st_wr_en  = 1'b1;
               wr_ptr_in = wr_next;
               if (walk_done) begin
                  count_in = wr_next;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_CPRD;
               end
            end else begin
               if (!dist_sts.evict) begin
                  st_wr_en  = 1'b1;
                  wr_ptr_in = wr_next;
               end
               state_in = walk_done ? ST_FIN : ST_RD;
            end
         end
         ST_CPRD: begin
            st_rd_en = 1'b1;
            state_in = ST_CPWR;
         end
         ST_CPWR: begin
            st_wr_en  = 1'b1;
            wr_ptr_in = wr_next;
            rd_ptr_in = rd_next;
            if (walk_done) begin
               count_in = wr_next;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_CPRD;
            end
         end
         ST_FIN: begin
            // append the new point unless the store is full
            st_wr_x = cur_x_ff;
            st_wr_y = cur_y_ff;
            if (wr_ptr_ff == CNT_W'(MAX_POINTS)) begin
               full_in  = 1'b1;
               count_in = wr_ptr_ff;
            end else begin
               st_wr_en = 1'b1;
               full_in  = 1'b0;
               count_in = wr_next;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output word valid
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         target_ff    <= TARGET_COLOR_RST;
         spacing_ff   <= SPACING_SQ_RST;
         window_ff    <= ROW_WINDOW_RST;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         target_ff    <= target_in;
         spacing_ff   <= spacing_in;
         window_ff    <= window_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_ptr_ff <= rd_ptr_in;
      wr_ptr_ff <= wr_ptr_in;
      cur_x_ff  <= cur_x_in;
      cur_y_ff  <= cur_y_in;
      full_ff   <= full_in;
      if (rsp_load) begin
         rsp_x_ff    <= FIELD_W'(cur_x_ff);
         rsp_y_ff    <= FIELD_W'(cur_y_ff);
         rsp_full_ff <= full_ff;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.point_x    = rsp_x_ff;
   assign rsp_if.point_y    = rsp_y_ff;
   assign rsp_if.store_full = rsp_full_ff;

endmodule

@@ rtl/bpss_store.sv @@
// ---------------------------------------------------------------------------
// bpss_store
// point store memory, one write port and one registered read port
// ---------------------------------------------------------------------------
module bpss_store import bpss_pkg::*; #(
   parameter int MAX_POINTS = 64,
   parameter int COORD_BITS = 12,
   parameter int PTR_W      = 6
) (
   input  logic                  clock,
   input  logic                  rd_en,
   input  logic [PTR_W-1:0]      rd_addr,
   output logic [COORD_BITS-1:0] rd_x,
   output logic [COORD_BITS-1:0] rd_y,
   input  logic                  wr_en,
   input  logic [PTR_W-1:0]      wr_addr,
   input  logic [COORD_BITS-1:0] wr_x,
   input  logic [COORD_BITS-1:0] wr_y
);

   localparam int WORD_W = 2 * COORD_BITS;

   logic [WORD_W-1:0] mem_ff [MAX_POINTS];
   logic [WORD_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= {wr_x, wr_y};
      end
   end

   // registered read port, holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_x = rd_data_ff[WORD_W-1:COORD_BITS];
   assign rd_y = rd_data_ff[COORD_BITS-1:0];

endmodule

@@ rtl/bpss_dist.sv @@
// ---------------------------------------------------------------------------
// bpss_dist
// shared distance unit: abs differences, one squarer used twice, compare
// ---------------------------------------------------------------------------
module bpss_dist import bpss_pkg::*; #(
   parameter int COORD_BITS = 12
) (
   input  logic                  clock,
   input  dist_ctl_type          ctl,
   input  logic [COORD_BITS-1:0] cur_x,
   input  logic [COORD_BITS-1:0] cur_y,
   input  logic [COORD_BITS-1:0] kept_x,
   input  logic [COORD_BITS-1:0] kept_y,
   input  logic [SPACING_W-1:0]  spacing_sq,
   input  logic [ROW_W-1:0]      row_window,
   output dist_sts_type          sts
);

   localparam int SQ_W  = 2 * COORD_BITS;
   localparam int SUM_W = SQ_W + 1;
   localparam int CMP_W = (SUM_W > SPACING_W) ? SUM_W : SPACING_W;
   localparam int WIN_W = (COORD_BITS > ROW_W) ? COORD_BITS : ROW_W;

   logic [COORD_BITS-1:0] dx_in, dx_ff;
   logic [COORD_BITS-1:0] dy_in, dy_ff;
   logic                  evict_in, evict_ff;
   logic [COORD_BITS-1:0] mul_op;
   logic [SQ_W-1:0]       prod_in, prod_ff;
   logic [SQ_W-1:0]       acc_ff;
   logic [CMP_W-1:0]      dist_sum;

   // absolute differences and row eviction test
   always_comb begin
      dx_in    = (cur_x >= kept_x) ? (cur_x - kept_x) : (kept_x - cur_x);
      dy_in    = (cur_y >= kept_y) ? (cur_y - kept_y) : (kept_y - cur_y);
      evict_in = WIN_W'(dy_in) > WIN_W'(row_window);
   end

   // one squarer, dx first then dy
   always_comb begin
      mul_op  = ctl.sq_x ? dx_ff : dy_ff;
      prod_in = {{COORD_BITS{1'b0}}, mul_op} * {{COORD_BITS{1'b0}}, mul_op};
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         dx_ff    <= dx_in;
         dy_ff    <= dy_in;
         evict_ff <= evict_in;
      end
      if (ctl.sq_x || ctl.sq_y) begin
         prod_ff <= prod_in;
      end
      if (ctl.sq_y) begin
         acc_ff <= prod_ff;
      end
   end

   // dx^2 + dy^2 against the spacing
   always_comb begin
      dist_sum      = CMP_W'(acc_ff) + CMP_W'(prod_ff);
      sts.too_close = dist_sum < CMP_W'(spacing_sq);
      sts.evict     = evict_ff;
   end

endmodule

@@ rtl/bpss_checker.sv @@
// ---------------------------------------------------------------------------
// bpss_checker
// port level checks of the sampler, bound to the top level
// ---------------------------------------------------------------------------
`include "boundary_point_spacing_sampler_assert.svh"

module bpss_checker import bpss_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic [COLOR_W-1:0]    req_center_color,
   input logic [COLOR_W-1:0]    req_up_color,
   input logic [COLOR_W-1:0]    req_right_color,
   input logic [COLOR_W-1:0]    req_down_color,
   input logic [COLOR_W-1:0]    req_left_color,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [FIELD_W-1:0]    rsp_point_x,
   input logic [FIELD_W-1:0]    rsp_point_y,
   input logic                  rsp_store_full,
   input logic                  csr_we,
   input csr_idx_type           csr_index,
   input logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [COLOR_W-1:0] target_ff;
   logic               req_accept;
   logic               is_boundary;

   // shadow of the target color register
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= TARGET_COLOR_RST;
      end else if (csr_we && (csr_index == CSR_TARGET_COLOR)) begin
         target_ff <= csr_wdata[COLOR_W-1:0];
      end
   end

   always_comb begin
      req_accept  = req_valid && req_ready;
      is_boundary = (req_center_color == target_ff) &&
                    ((req_up_color    != target_ff) ||
                     (req_right_color != target_ff) ||
                     (req_down_color  != target_ff) ||
                     (req_left_color  != target_ff));
   end

   // stalled output word holds
   `BPSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable({rsp_point_x, rsp_point_y, rsp_store_full}), "output word changed while stalled")

   // reset empties the output
   `BPSS_ASSERT_NEXT(a_rsp_reset, clock, 1'b0, reset, !rsp_valid, "output valid after reset")

   // non-boundary pixel leaves the input ready in the next cycle with no word
   `BPSS_ASSERT_NEXT(a_plain_pass, clock, reset, req_accept && !is_boundary, req_ready && !$rose(rsp_valid), "non-boundary pixel stalled or emitted")

   // boundary pixel starts a store scan or an append
   `BPSS_ASSERT_NEXT(a_boundary_busy, clock, reset, req_accept && is_boundary, !req_ready, "boundary pixel did not start a scan")

endmodule

bind boundary_point_spacing_sampler bpss_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .req_center_color (req_if.center_color),
   .req_up_color     (req_if.up_color),
   .req_right_color  (req_if.right_color),
   .req_down_color   (req_if.down_color),
   .req_left_color   (req_if.left_color),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_point_x      (rsp_if.point_x),
   .rsp_point_y      (rsp_if.point_y),
   .rsp_store_full   (rsp_if.store_full),
   .csr_we           (csr_we),
   .csr_index        (csr_index),
   .csr_wdata        (csr_wdata)
);
